/* hw/rtl/bsl_pkg.sv */
// Shared types and constants for the lower-bound search block.
package bsl_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned RESULT_W = 11;
  localparam int unsigned LEN_W    = 11;

  // Request kinds carried by req_type.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Register index decoded from paddr[2].
  localparam logic REG_ARRAY_LENGTH = 1'b0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // write the input value into the table
    logic start;    // open the search interval and capture the target
    logic step;     // compare the probed entry and narrow the interval
    logic publish;  // copy the final position into the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;     // search interval is empty
  } status_t;

endpackage

/* hw/rtl/bsl_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module bsl_ram #(
  parameter  int unsigned Width = 32,
  parameter  int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/bsl_dpath.sv */
// Datapath: table memory, search interval registers and result register.
module bsl_dpath #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  bsl_pkg::cmd_t                        cmd_i,
  output bsl_pkg::status_t                     status_o,
  input  logic [bsl_pkg::LEN_W-1:0]            array_length_i,
  input  logic [bsl_pkg::INDEX_W-1:0]          entry_index_i,
  input  logic signed [bsl_pkg::VALUE_W-1:0]   item_value_i,
  output logic [bsl_pkg::RESULT_W-1:0]         insert_index_o
);

  localparam int unsigned AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  // Interval bounds range from 0 to TABLE_DEPTH inclusive.
  localparam int unsigned LW = $clog2(TABLE_DEPTH + 1);

  // Half-open interval [lo, hi): hi is one past the last candidate.
  logic [LW-1:0]                       lo_q, lo_d;
  logic [LW-1:0]                       hi_q, hi_d;
  logic signed [bsl_pkg::VALUE_W-1:0]  target_q;
  logic [bsl_pkg::RESULT_W-1:0]        result_q;
  logic [LW-1:0]                       eff_len;
  logic [LW-1:0]                       span;
  logic [LW-1:0]                       mid;
  logic                                wr_en;
  logic [bsl_pkg::VALUE_W-1:0]         rd_data;
  logic                                probe_below;

  assign eff_len = (32'(array_length_i) > 32'(TABLE_DEPTH)) ? LW'(TABLE_DEPTH)
                                                           : LW'(array_length_i);

  // Only meaningful while lo < hi, when the span is non-negative.
  assign span = hi_q - lo_q - LW'(1);
  assign mid  = lo_q + (span >> 1);

  assign wr_en = cmd_i.load && (32'(entry_index_i) < 32'(TABLE_DEPTH));

  bsl_ram #(
    .Width(bsl_pkg::VALUE_W),
    .Depth(TABLE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(AddrW'(entry_index_i)),
    .wdata_i(item_value_i),
    .raddr_i(AddrW'(mid)),
    .rdata_o(rd_data)
  );

  assign probe_below = $signed(rd_data) < target_q;

  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (cmd_i.start) begin
      lo_d = '0;
      hi_d = eff_len;
    end else if (cmd_i.step) begin
      if (probe_below) begin
        lo_d = mid + LW'(1);
      end else begin
        hi_d = mid;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q <= '0;
      hi_q <= '0;
    end else begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      target_q <= item_value_i;
    end
    if (cmd_i.publish) begin
      result_q <= bsl_pkg::RESULT_W'(lo_q);
    end
  end

  assign status_o.done  = (lo_q >= hi_q);
  assign insert_index_o = result_q;

  // The interval never inverts: each step keeps lo at or below hi.
  a_interval_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lo_q <= hi_q)
    else $error("search interval inverted");

endmodule

/* hw/rtl/bsl_ctrl.sv */
// Controller: handshakes and the probe sequencer of the search.
module bsl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              req_type_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  bsl_pkg::status_t  status_i,
  output bsl_pkg::cmd_t     cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;  // waiting for a transaction
  localparam logic [1:0] S_READ = 2'd1;  // memory read of the middle entry in flight
  localparam logic [1:0] S_CMP  = 2'd2;  // read data present, narrow the interval
  localparam logic [1:0] S_FIN  = 2'd3;  // hand the position to the result register

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_fire;
  logic       slot_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.load    = in_fire && (req_type_i == bsl_pkg::REQ_LOAD);
    cmd_o.start   = in_fire && (req_type_i == bsl_pkg::REQ_QUERY);
    case (state_q)
      S_IDLE: begin
        if (cmd_o.start) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = status_i.done ? S_FIN : S_CMP;
      end
      S_CMP: begin
        cmd_o.step = 1'b1;
        state_d    = S_READ;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd_o.publish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.publish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_cmp_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CMP |-> $past(state_q) == S_READ)
    else $error("compare without a preceding memory read");

  a_query_starts_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> state_q == S_READ)
    else $error("accepted query did not start a probe");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |-> (!out_valid_q || out_ready_i))
    else $error("pending result overwritten");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.start, cmd_o.step, cmd_o.publish}))
    else $error("conflicting datapath commands");

endmodule

/* hw/rtl/binary_search_lower_bound.sv */
// Top level of the sorted-table lower-bound search block.
//
//   Port group    Direction  Handshake        Carries
//   input item    in         in_valid/ready   req_type, entry_index, item_value
//   result item   out        out_valid/ready  insert_index
//   config        in/out     APB psel/penable array_length at address 0
//
// A load transaction writes the table directly. A query for an effective
// length n > 0 needs at most floor(log2(n)) + 1 probes. Each probe is a
// registered memory read followed by a compare. Input is taken only while no
// query runs. A finished result waits in an output register, so the next
// transaction is taken while it is unread; a later query stalls before
// publishing until that result is read. Reset clears control state and
// array_length; the table contents are undefined until loaded.
module binary_search_lower_bound #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 req_type_i,
  input  logic [bsl_pkg::INDEX_W-1:0]          entry_index_i,
  input  logic signed [bsl_pkg::VALUE_W-1:0]   item_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [bsl_pkg::RESULT_W-1:0]         insert_index_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  logic [bsl_pkg::LEN_W-1:0] array_length_q, array_length_d;
  logic                      cfg_write;
  bsl_pkg::cmd_t             cmd;
  bsl_pkg::status_t          status;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready
                     && (paddr[2] == bsl_pkg::REG_ARRAY_LENGTH);

  assign array_length_d = cfg_write ? pwdata[bsl_pkg::LEN_W-1:0] : array_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      array_length_q <= '0;
    end else begin
      array_length_q <= array_length_d;
    end
  end

  assign prdata = (paddr[2] == bsl_pkg::REG_ARRAY_LENGTH) ? 32'(array_length_q) : '0;

  bsl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_type_i (req_type_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bsl_dpath #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .array_length_i(array_length_q),
    .entry_index_i (entry_index_i),
    .item_value_i  (item_value_i),
    .insert_index_o(insert_index_o)
  );

endmodule
